// ===== hdl/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, constants and tables for the buzzer tune sequencer.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Configuration register file
  localparam int NUM_REGS  = 8;
  localparam int LEN_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_LEN_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_LEN_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIVE_LEN1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIVE_LEN5 = 3'd7;

  typedef logic [NUM_REGS-1:0][LEN_W-1:0] len_arr_t;

  // Reset lengths, highest register first
  localparam len_arr_t LEN_RESET = {8'd3, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd2};

  // Pre-start length in 10 ms periods
  localparam int PRESTART_TENS_DEF = 5;

  // Field widths
  localparam int TONE_W = 12;
  localparam int TUNE_W = 2;

  // Word operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PLAY = 1'b1;

  // Tune selectors (tune three plays as the five-note tune)
  localparam logic [TUNE_W-1:0] TUNE_KEY  = 2'd0;
  localparam logic [TUNE_W-1:0] TUNE_TWO  = 2'd1;
  localparam logic [TUNE_W-1:0] TUNE_FIVE = 2'd2;

  // Time bases
  localparam logic [3:0] TEN_MS_FULL     = 4'd10;
  localparam logic [6:0] HUNDRED_MS_FULL = 7'd100;

  // Note steps
  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_TWO_B = 3'd1;
  localparam logic [2:0] STEP_LAST5 = 3'd4;

  // Frequencies
  localparam logic [TONE_W-1:0] HZ_OFF  = 12'd0;
  localparam logic [TONE_W-1:0] HZ_1000 = 12'd1000;
  localparam logic [TONE_W-1:0] HZ_1250 = 12'd1250;
  localparam logic [TONE_W-1:0] HZ_1428 = 12'd1428;
  localparam logic [TONE_W-1:0] HZ_1538 = 12'd1538;
  localparam logic [TONE_W-1:0] HZ_2000 = 12'd2000;
  localparam logic [TONE_W-1:0] HZ_2500 = 12'd2500;

  // Sequencer state
  typedef struct packed {
    logic [TUNE_W-1:0] tune;
    logic              prestart_active;
    logic [7:0]        prestart_count;
    logic              notes_enabled;
    logic [7:0]        note_time;
    logic [2:0]        note_step;
    logic [3:0]        ten_ms;
    logic [6:0]        hundred_ms;
    logic              disable_pending;
    logic [TONE_W-1:0] freq;
    logic              pin;
  } state_t;

  // Result word fields
  typedef struct packed {
    logic              busy;
    logic              pin;
    logic [TONE_W-1:0] tone_hz;
  } result_t;

  // Five-note tune frequency table
  function automatic logic [TONE_W-1:0] five_freq(input logic [2:0] idx);
    logic [TONE_W-1:0] hz;
    case (idx)
      3'd0:    hz = HZ_1000;
      3'd1:    hz = HZ_1250;
      3'd2:    hz = HZ_1428;
      3'd3:    hz = HZ_2000;
      3'd4:    hz = HZ_2500;
      default: hz = HZ_OFF;
    endcase
    return hz;
  endfunction

endpackage

// ===== hdl/bts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bts_cfg_regs
// Note length register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bts_cfg_regs
  import bts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  output len_arr_t             len_o
);

  len_arr_t len_r;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      len_r[cfg_index] <= cfg_data;
    end
  end

  assign len_o = len_r;

endmodule

// ===== hdl/bts_core.sv =====
// ----------------------------------------------------------------------------
// bts_core
// Sequencer state and its next-state logic, advanced once per word.
// ----------------------------------------------------------------------------
module bts_core
  import bts_pkg::*;
#(
  parameter int PRESTART_TENS = PRESTART_TENS_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              op,
  input  logic [TUNE_W-1:0] tune,
  input  len_arr_t          len_i,
  output result_t           res_o
);

  localparam logic [7:0] PRESTART_LIM = 8'(PRESTART_TENS);

  state_t     st_r;
  state_t     st_nxt;
  logic [7:0] len_sel;

  // Next state: time bases, request, pre-start, note phase, tone-off
  always_comb begin
    st_nxt  = st_r;
    len_sel = '0;

    if (op == OP_TICK) begin
      if (st_nxt.ten_ms < TEN_MS_FULL) st_nxt.ten_ms = st_nxt.ten_ms + 4'd1;
      if (st_nxt.hundred_ms < HUNDRED_MS_FULL) st_nxt.hundred_ms = st_nxt.hundred_ms + 7'd1;
    end else begin
      st_nxt.tune            = tune;
      st_nxt.prestart_active = 1'b1;
      st_nxt.prestart_count  = 8'd0;
      st_nxt.note_time       = 8'd0;
      st_nxt.note_step       = STEP_FIRST;
      st_nxt.notes_enabled   = 1'b0;
      st_nxt.freq            = HZ_OFF;
      st_nxt.pin             = 1'b1;
    end

    // Pre-start phase in 10 ms periods
    if (st_nxt.prestart_active && st_nxt.ten_ms >= TEN_MS_FULL) begin
      st_nxt.ten_ms         = 4'd0;
      st_nxt.prestart_count = st_nxt.prestart_count + 8'd1;
      if (st_nxt.prestart_count == PRESTART_LIM) begin
        st_nxt.prestart_count  = 8'd0;
        st_nxt.prestart_active = 1'b0;
        st_nxt.notes_enabled   = 1'b1;
        st_nxt.pin             = 1'b0;
        if (st_nxt.tune == TUNE_KEY) st_nxt.freq = HZ_1538;
      end
    end

    // Note phase in 100 ms periods
    if (st_nxt.notes_enabled && st_nxt.hundred_ms >= HUNDRED_MS_FULL) begin
      st_nxt.hundred_ms = 7'd0;
      st_nxt.note_time  = st_nxt.note_time + 8'd1;
      case (st_nxt.tune)
        TUNE_KEY: begin
          if (st_nxt.note_time >= len_i[REG_KEY_LEN]) begin
            st_nxt.note_time     = 8'd0;
            st_nxt.notes_enabled = 1'b0;
          end else if (st_nxt.note_time == 8'd1) begin
            st_nxt.freq = HZ_1538;
          end
        end
        TUNE_TWO: begin
          if (st_nxt.note_step == STEP_FIRST) begin
            if (st_nxt.note_time >= len_i[REG_TWO_LEN_A]) begin
              st_nxt.note_time       = 8'd0;
              st_nxt.note_step       = st_nxt.note_step + 3'd1;
              st_nxt.freq            = HZ_1000;
              st_nxt.prestart_active = 1'b1;
              st_nxt.pin             = 1'b1;
            end else if (st_nxt.note_time == 8'd1) begin
              st_nxt.freq = HZ_1538;
            end
          end else if (st_nxt.note_step == STEP_TWO_B) begin
            if (st_nxt.note_time >= len_i[REG_TWO_LEN_B]) begin
              st_nxt.note_time     = 8'd0;
              st_nxt.notes_enabled = 1'b0;
            end
          end
        end
        default: begin
          // five-note tune, tune three included; step may just have been cleared
          len_sel = len_i[3'(st_nxt.note_step + REG_FIVE_LEN1)];
          if (st_nxt.note_step < STEP_LAST5) begin
            if (st_nxt.note_time == len_sel) begin
              st_nxt.freq            = five_freq(st_nxt.note_step + 3'd1);
              st_nxt.note_time       = 8'd0;
              st_nxt.note_step       = st_nxt.note_step + 3'd1;
              st_nxt.prestart_active = 1'b1;
              st_nxt.pin             = 1'b1;
            end else if (st_nxt.note_step == STEP_FIRST && st_nxt.note_time == 8'd1) begin
              st_nxt.freq = HZ_1000;
            end
          end else if (st_nxt.note_step == STEP_LAST5) begin
            if (st_nxt.note_time == len_i[REG_FIVE_LEN5]) begin
              st_nxt.note_time     = 8'd0;
              st_nxt.notes_enabled = 1'b0;
            end
          end
        end
      endcase
    end

    // Tone goes off when timing stops, if timing also ran in the word before
    if (!st_nxt.notes_enabled) begin
      if (st_nxt.disable_pending) st_nxt.freq = HZ_OFF;
      st_nxt.disable_pending = 1'b0;
    end else begin
      st_nxt.disable_pending = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  // Result follows the updated state
  assign res_o.tone_hz = st_nxt.freq;
  assign res_o.pin     = st_nxt.pin;
  assign res_o.busy    = st_nxt.notes_enabled;

endmodule

// ===== hdl/buzzer_tune_sequencer.sv =====
// ----------------------------------------------------------------------------
// buzzer_tune_sequencer
// Plays key beep, two-note and five-note buzzer tunes off 1 ms tick words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | sink      | in_tvalid/tready    | tuser: operation; tdata: tune
//  out_    | source    | out_tvalid/tready   | tdata: tone_hz, pin, busy
//  cfg_    | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data (length)
//
//  One word a cycle is taken; it passes the input register and then the result
//  register before its result word is offered. Rate is set by the sequencer
//  state update, one word per clock while the result side does not stall.
//  While a result waits, the input register takes one more word, then the
//  input side stalls until the result word drains.
//  Synchronous active-low reset clears state and loads the default lengths.
// ----------------------------------------------------------------------------
module buzzer_tune_sequencer
  import bts_pkg::*;
#(
  parameter int PRESTART_TENS = PRESTART_TENS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [1:0] tune
  input  logic [0:0]           in_tuser,   // [0] operation
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [11:0] tone_hz, [12] prestart_pin, [13] busy_res
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  logic              s1_valid_r;
  logic              s1_op_r;
  logic [TUNE_W-1:0] s1_tune_r;
  logic              s1_adv;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           core_res;
  len_arr_t          len;

  bts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .len_o     (len)
  );

  // Input stage moves on when the result register is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser[0];
      s1_tune_r <= in_tdata[TUNE_W-1:0];
    end
  end

  bts_core #(
    .PRESTART_TENS (PRESTART_TENS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .op      (s1_op_r),
    .tune    (s1_tune_r),
    .len_i   (len),
    .res_o   (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_res_r <= core_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

// ===== hdl/bts_checker.sv =====
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks on the buzzer tune sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bts_checker
  import bts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Input back-pressure only comes from a stalled result
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with result side free");

  // Tone never exceeds the highest note
  a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TONE_W-1:0] <= HZ_2500)
    else $error("tone out of range");

  // No result word straight after reset
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind buzzer_tune_sequencer bts_checker u_bts_checker (.*);

// ===== bench/tb_buzzer_tune_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buzzer_tune_sequencer
// Self-checking bench for the buzzer tune sequencer. Tick and play words are
// streamed in under random sender gaps and receiver stalls. A word-level
// model of the sequencer predicts each result word, and a scoreboard compares
// the results in order. Note lengths are reloaded between phases, including
// the shortest and longest settings.
// ----------------------------------------------------------------------------
module tb_buzzer_tune_sequencer;
  import bts_pkg::*;

  localparam logic [TUNE_W-1:0] TUNE_THREE = 2'd3;
  localparam logic [LEN_W-1:0]  LEN_MIN    = 8'd1;
  localparam logic [LEN_W-1:0]  LEN_MAX    = 8'd255;
  localparam int                CYCLE_LIMIT = 400000;
  localparam int                REPORT_MAX  = 10;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // --------------------------------------------------------------------------
  // Tone predictor and result store
  // --------------------------------------------------------------------------
  class tone_scoreboard;
    state_t            seq;
    logic [LEN_W-1:0]  len [NUM_REGS];
    logic [TONE_W-1:0] five_hz [5];
    result_t           expected_tones [$];
    int                mismatches;

    function new();
      seq = '0;
      for (int i = 0; i < NUM_REGS; i++) len[i] = LEN_RESET[i];
      five_hz = '{HZ_1000, HZ_1250, HZ_1428, HZ_2000, HZ_2500};
      mismatches = 0;
    endfunction

    function void load_len(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
      len[idx] = val;
    endfunction

    function int pending();
      return expected_tones.size();
    endfunction

    // Move on to the next note; pre-start pin goes up again
    function void start_note(logic [TONE_W-1:0] hz);
      seq.note_time       = '0;
      seq.note_step       = seq.note_step + 3'd1;
      seq.freq            = hz;
      seq.prestart_active = 1'b1;
      seq.pin             = 1'b1;
    endfunction

    function void end_tune();
      seq.note_time     = '0;
      seq.notes_enabled = 1'b0;
    endfunction

    // One 100 ms note period
    function void note_period();
      seq.note_time = seq.note_time + 8'd1;
      if (seq.tune == TUNE_KEY) begin
        if (seq.note_time >= len[REG_KEY_LEN]) end_tune();
        else if (seq.note_time == 8'd1) seq.freq = HZ_1538;
      end else if (seq.tune == TUNE_TWO) begin
        if (seq.note_step == STEP_FIRST) begin
          if (seq.note_time >= len[REG_TWO_LEN_A]) start_note(HZ_1000);
          else if (seq.note_time == 8'd1) seq.freq = HZ_1538;
        end else if (seq.note_step == STEP_TWO_B) begin
          if (seq.note_time >= len[REG_TWO_LEN_B]) end_tune();
        end
      end else begin
        // five-note tune, tune three included; exact match on length
        if (seq.note_step < STEP_LAST5) begin
          if (seq.note_time == len[REG_FIVE_LEN1 + seq.note_step])
            start_note(five_hz[seq.note_step + 3'd1]);
          else if (seq.note_step == STEP_FIRST && seq.note_time == 8'd1)
            seq.freq = five_hz[0];
        end else if (seq.note_step == STEP_LAST5) begin
          if (seq.note_time == len[REG_FIVE_LEN5]) end_tune();
        end
      end
    endfunction

    // Accepted input word: advance the model, queue the expected result
    function void predict_word(logic op, logic [TUNE_W-1:0] sel);
      result_t res;
      if (op == OP_TICK) begin
        if (seq.ten_ms < TEN_MS_FULL) seq.ten_ms = seq.ten_ms + 4'd1;
        if (seq.hundred_ms < HUNDRED_MS_FULL) seq.hundred_ms = seq.hundred_ms + 7'd1;
      end else begin
        seq.tune            = sel;
        seq.prestart_active = 1'b1;
        seq.prestart_count  = '0;
        seq.note_time       = '0;
        seq.note_step       = STEP_FIRST;
        seq.notes_enabled   = 1'b0;
        seq.freq            = HZ_OFF;
        seq.pin             = 1'b1;
      end

      // pre-start phase, 10 ms periods
      if (seq.prestart_active && seq.ten_ms >= TEN_MS_FULL) begin
        seq.ten_ms         = '0;
        seq.prestart_count = seq.prestart_count + 8'd1;
        if (seq.prestart_count == 8'(PRESTART_TENS_DEF)) begin
          seq.prestart_count  = '0;
          seq.prestart_active = 1'b0;
          seq.notes_enabled   = 1'b1;
          seq.pin             = 1'b0;
          if (seq.tune == TUNE_KEY) seq.freq = HZ_1538;
        end
      end

      // note phase, 100 ms periods
      if (seq.notes_enabled && seq.hundred_ms >= HUNDRED_MS_FULL) begin
        seq.hundred_ms = '0;
        note_period();
      end

      // tone goes off when timing stops, if timing also ran in the word before
      if (!seq.notes_enabled) begin
        if (seq.disable_pending) seq.freq = HZ_OFF;
        seq.disable_pending = 1'b0;
      end else begin
        seq.disable_pending = 1'b1;
      end

      res.tone_hz = seq.freq;
      res.pin     = seq.pin;
      res.busy    = seq.notes_enabled;
      expected_tones.push_back(res);
    endfunction

    // Accepted result word: compare with the oldest expectation
    function void check_word(logic [15:0] data);
      result_t got;
      result_t want;
      got = data[13:0];
      if (expected_tones.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with none expected: tone %0d pin %b busy %b",
                   $time, got.tone_hz, got.pin, got.busy);
        return;
      end
      want = expected_tones.pop_front();
      if (got.tone_hz !== want.tone_hz || got.pin !== want.pin ||
          got.busy !== want.busy) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: mismatch: exp tone %0d pin %b busy %b, got tone %0d pin %b busy %b",
                   $time, want.tone_hz, want.pin, want.busy,
                   got.tone_hz, got.pin, got.busy);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic [0:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [15:0]          out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [LEN_W-1:0]     cfg_data   = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buzzer_tune_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tone_scoreboard   tones = new();
  int               send_gap_pct   = 0;
  int               recv_stall_pct = 0;
  int               words_sent     = 0;
  int               cycles         = 0;
  logic [LEN_W-1:0] len_plan [NUM_REGS];

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL buzzer_tune_sequencer");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Monitor: config writes, accepted words, result words, in that order
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tones.load_len(cfg_index, cfg_data);
      if (in_tvalid && in_tready) tones.predict_word(in_tuser[0], in_tdata[TUNE_W-1:0]);
      if (out_tvalid && out_tready) tones.check_word(out_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic set_idle(input idle_mode_e mode);
    send_gap_pct   = (mode == IDLE_SEND) ? 67 : (mode == IDLE_BOTH) ? 32 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 67 : (mode == IDLE_BOTH) ? 32 : 0;
  endtask

  task automatic send_word(input logic op, input logic [TUNE_W-1:0] sel);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(8-TUNE_W){1'b0}}, sel};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tones.pending() != 0) @(posedge clk);
  endtask

  // Load all length registers from len_plan; block is idle here
  task automatic write_lens();
    drain();
    repeat (4) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= len_plan[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic plan_random(input int lo, input int hi);
    for (int i = 0; i < NUM_REGS; i++) len_plan[i] = LEN_W'($urandom_range(hi, lo));
  endtask

  // A play request (mostly) followed by a run of ticks, sometimes cut short
  task automatic play_sequence(input int budget_left);
    int ticks;
    if ($urandom_range(5) != 0) begin
      send_word(OP_PLAY, TUNE_W'($urandom_range(3)));
      if ($urandom_range(7) == 0) send_word(OP_PLAY, TUNE_W'($urandom_range(3)));
    end
    ticks = ($urandom_range(3) == 0) ? $urandom_range(60, 1) : $urandom_range(650, 120);
    if (ticks > budget_left) ticks = budget_left;
    if (ticks < 1) ticks = 1;
    repeat (ticks) send_word(OP_TICK, TUNE_W'($urandom_range(3)));
  endtask

  task automatic run_phase(input int budget);
    int start;
    start = words_sent;
    while (words_sent - start < budget) play_sequence(budget - (words_sent - start));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ticks with ignored tune bits, every tune, back-to-back plays
    set_idle(IDLE_NONE);
    send_word(OP_TICK, TUNE_THREE);
    send_word(OP_TICK, TUNE_KEY);
    send_word(OP_PLAY, TUNE_KEY);
    repeat (3) send_word(OP_TICK, TUNE_TWO);
    send_word(OP_PLAY, TUNE_TWO);
    send_word(OP_PLAY, TUNE_FIVE);
    send_word(OP_PLAY, TUNE_THREE);
    repeat (4) send_word(OP_TICK, TUNE_THREE);
    send_word(OP_PLAY, TUNE_FIVE);
    send_word(OP_TICK, TUNE_FIVE);
    send_word(OP_PLAY, TUNE_TWO);
    repeat (3) send_word(OP_TICK, TUNE_KEY);
    send_word(OP_PLAY, TUNE_THREE);

    // shortest notes: tunes finish quickly, late-end case
    for (int i = 0; i < NUM_REGS; i++) len_plan[i] = LEN_MIN;
    write_lens();
    set_idle(IDLE_NONE);
    run_phase(380);

    // mixed short lengths, sender gaps, one full pause mid-phase
    plan_random(1, 3);
    write_lens();
    set_idle(IDLE_SEND);
    run_phase(190);
    drain();
    run_phase(190);

    // longest notes, receiver stalls
    for (int i = 0; i < NUM_REGS; i++) len_plan[i] = LEN_MAX;
    write_lens();
    set_idle(IDLE_RECV);
    run_phase(200);

    plan_random(1, 2);
    write_lens();
    set_idle(IDLE_BOTH);
    run_phase(380);

    // back to reset lengths
    for (int i = 0; i < NUM_REGS; i++) len_plan[i] = LEN_RESET[i];
    write_lens();
    set_idle(IDLE_NONE);
    run_phase(490);

    drain();
    repeat (10) @(posedge clk);
    if (tones.mismatches == 0 && tones.pending() == 0) begin
      $display("PASS buzzer_tune_sequencer");
    end else begin
      $display("FAIL buzzer_tune_sequencer");
    end
    $finish;
  end

endmodule
